/* sv/tgi_pkg.sv */
`timescale 1ns / 1ps
// Shared constants, types and helpers of the trilinear grid interpolator.
package tgi_pkg;

   localparam int POINTS_X = 16;
   localparam int POINTS_Y = 16;
   localparam int POINTS_Z = 16;

   localparam int DATA_W      = 32;
   localparam int TABLE_DEPTH = 4096;
   localparam int ADDR_W      = $clog2(TABLE_DEPTH);
   localparam int CORNERS     = 8;

   localparam int POINTS_MAX = (POINTS_X > POINTS_Y) ?
                               ((POINTS_X > POINTS_Z) ? POINTS_X : POINTS_Z) :
                               ((POINTS_Y > POINTS_Z) ? POINTS_Y : POINTS_Z);
   localparam int IDX_W  = $clog2(POINTS_MAX);
   localparam int FLAT_W = 3 * IDX_W + 2;
   localparam int PLANE  = POINTS_Y * POINTS_Z;

   localparam int FRAC_W = 16;
   localparam int DIFF_W = DATA_W + 1;
   localparam int PROD_W = DIFF_W + DATA_W;
   localparam int T_W    = PROD_W - FRAC_W;
   localparam int RAW_W  = T_W - FRAC_W;
   localparam int WSUM_W = T_W + 1;

   localparam int STAGES = 12;
   localparam int CSR_W  = 3;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   typedef enum logic [CSR_W-1:0] {
      CSR_ORIGIN_X = 3'd0,
      CSR_ORIGIN_Y = 3'd1,
      CSR_ORIGIN_Z = 3'd2,
      CSR_SCALE_X  = 3'd3,
      CSR_SCALE_Y  = 3'd4,
      CSR_SCALE_Z  = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic diff;
      logic mul;
      logic split;
   } axis_en_type;

   typedef struct packed {
      logic mul;
      logic add;
   } lerp_en_type;

   // {clipped, value}: clip a wide signed sum to the 32-bit range
   function automatic logic [DATA_W:0] sat32(input logic signed [WSUM_W-1:0] v);
      logic [WSUM_W-DATA_W:0] top;
      logic [DATA_W:0]        res;
      top = v[WSUM_W-1:DATA_W-1];
      if (top == '0 || top == '1) begin
         res = {1'b0, v[DATA_W-1:0]};
      end else if (v[WSUM_W-1]) begin
         res = {1'b1, 1'b1, {(DATA_W-1){1'b0}}};
      end else begin
         res = {1'b1, 1'b0, {(DATA_W-1){1'b1}}};
      end
      return res;
   endfunction

endpackage

/* sv/tgi_ram.sv */
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module tgi_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/tgi_axis.sv */
`timescale 1ns / 1ps
// One axis: offset, scale, then split into clamped cell index and weight.
module tgi_axis (
   input  logic                              clock,
   input  tgi_pkg::axis_en_type              en,
   input  logic signed [tgi_pkg::DATA_W-1:0] coord,
   input  logic signed [tgi_pkg::DATA_W-1:0] origin,
   input  logic signed [tgi_pkg::DATA_W-1:0] scale,
   input  logic        [tgi_pkg::IDX_W-1:0]  max_index,
   output logic        [tgi_pkg::IDX_W-1:0]  idx,
   output logic signed [tgi_pkg::DATA_W-1:0] weight,
   output logic                              clipped
);

   logic signed [tgi_pkg::DIFF_W-1:0] diff_in, diff_ff;
   logic signed [tgi_pkg::PROD_W-1:0] prod_in, prod_ff;
   logic signed [tgi_pkg::T_W-1:0]    t_val;
   logic signed [tgi_pkg::RAW_W-1:0]  raw;
   logic        [tgi_pkg::IDX_W-1:0]  idx_in, idx_ff;
   logic signed [tgi_pkg::WSUM_W-1:0] wsum;
   logic        [tgi_pkg::DATA_W:0]   wsat;
   logic signed [tgi_pkg::DATA_W-1:0] weight_ff;
   logic                              clipped_ff;

   assign diff_in = tgi_pkg::DIFF_W'(coord) - tgi_pkg::DIFF_W'(origin);
   assign prod_in = tgi_pkg::PROD_W'(diff_ff) * tgi_pkg::PROD_W'(scale);

   // floor shifts are arithmetic right shifts
   assign t_val = prod_ff[tgi_pkg::PROD_W-1:tgi_pkg::FRAC_W];
   assign raw   = t_val[tgi_pkg::T_W-1:tgi_pkg::FRAC_W];

   always_comb begin
      if (raw[tgi_pkg::RAW_W-1]) begin
         idx_in = '0;
      end else if (raw > $signed(tgi_pkg::RAW_W'(max_index))) begin
         idx_in = max_index;
      end else begin
         idx_in = raw[tgi_pkg::IDX_W-1:0];
      end
   end

   // weight is not clamped: out-of-grid queries extrapolate
   assign wsum = tgi_pkg::WSUM_W'(t_val)
               - $signed(tgi_pkg::WSUM_W'({idx_in, {tgi_pkg::FRAC_W{1'b0}}}));
   assign wsat = tgi_pkg::sat32(wsum);

   always_ff @(posedge clock) begin
      if (en.diff) begin
         diff_ff <= diff_in;
      end
      if (en.mul) begin
         prod_ff <= prod_in;
      end
      if (en.split) begin
         idx_ff     <= idx_in;
         weight_ff  <= wsat[tgi_pkg::DATA_W-1:0];
         clipped_ff <= wsat[tgi_pkg::DATA_W];
      end
   end

   assign idx     = idx_ff;
   assign weight  = weight_ff;
   assign clipped = clipped_ff;

endmodule

/* sv/tgi_lerp.sv */
`timescale 1ns / 1ps
// Two-stage saturating blend a + floor(w*(b-a) / 2^16).
module tgi_lerp (
   input  logic                              clock,
   input  tgi_pkg::lerp_en_type              en,
   input  logic signed [tgi_pkg::DATA_W-1:0] a,
   input  logic signed [tgi_pkg::DATA_W-1:0] b,
   input  logic signed [tgi_pkg::DATA_W-1:0] w,
   output logic signed [tgi_pkg::DATA_W-1:0] res,
   output logic                              clipped
);

   logic signed [tgi_pkg::DIFF_W-1:0] diff;
   logic signed [tgi_pkg::PROD_W-1:0] prod_in, prod_ff;
   logic signed [tgi_pkg::DATA_W-1:0] a_ff;
   logic signed [tgi_pkg::WSUM_W-1:0] sum;
   logic        [tgi_pkg::DATA_W:0]   sat;
   logic signed [tgi_pkg::DATA_W-1:0] res_ff;
   logic                              clipped_ff;

   assign diff    = tgi_pkg::DIFF_W'(b) - tgi_pkg::DIFF_W'(a);
   assign prod_in = tgi_pkg::PROD_W'(w) * tgi_pkg::PROD_W'(diff);

   assign sum = tgi_pkg::WSUM_W'(a_ff)
              + tgi_pkg::WSUM_W'($signed(prod_ff[tgi_pkg::PROD_W-1:tgi_pkg::FRAC_W]));
   assign sat = tgi_pkg::sat32(sum);

   always_ff @(posedge clock) begin
      if (en.mul) begin
         prod_ff <= prod_in;
         a_ff    <= a;
      end
      if (en.add) begin
         res_ff     <= sat[tgi_pkg::DATA_W-1:0];
         clipped_ff <= sat[tgi_pkg::DATA_W];
      end
   end

   assign res     = res_ff;
   assign clipped = clipped_ff;

endmodule

/* sv/trilinear_grid_interpolation.sv */
`timescale 1ns / 1ps
// Trilinear grid interpolator: top level with pipeline control and grid table.
//
// A transaction is either a table write or a query. The pipeline takes one
// transaction every cycle while the input is not stalled, and holds twelve
// register stages. The grid is held in eight copies of a 4096-entry RAM,
// one per cell corner, so all eight corners of a cell are read in the same
// cycle; every table write goes to all copies, in order with the queries
// around it. The only stall comes from the result side, and the input stalls
// only once every stage is full. Reading an entry that was never written
// returns an undefined value. Configuration registers may be written only
// while no transaction is in flight.
module trilinear_grid_interpolation (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_operation,
   input  logic        [tgi_pkg::ADDR_W-1:0]  req_table_address,
   input  logic signed [tgi_pkg::DATA_W-1:0]  req_table_value,
   input  logic signed [tgi_pkg::DATA_W-1:0]  req_coord_x,
   input  logic signed [tgi_pkg::DATA_W-1:0]  req_coord_y,
   input  logic signed [tgi_pkg::DATA_W-1:0]  req_coord_z,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [tgi_pkg::DATA_W-1:0]  rsp_interpolated,
   output logic                               rsp_saturated,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic        [tgi_pkg::CSR_W-1:0]   csr_index,
   input  logic        [tgi_pkg::DATA_W-1:0]  csr_data
);

   localparam int S = tgi_pkg::STAGES;

   // configuration
   logic signed [tgi_pkg::DATA_W-1:0] origin_x_ff, origin_y_ff, origin_z_ff;
   logic signed [tgi_pkg::DATA_W-1:0] scale_x_ff, scale_y_ff, scale_z_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff <= '0;
         origin_y_ff <= '0;
         origin_z_ff <= '0;
         scale_x_ff  <= tgi_pkg::DATA_W'(65536);
         scale_y_ff  <= tgi_pkg::DATA_W'(65536);
         scale_z_ff  <= tgi_pkg::DATA_W'(65536);
      end else if (csr_valid && csr_ready) begin
         unique case (tgi_pkg::csr_index_type'(csr_index))
            tgi_pkg::CSR_ORIGIN_X: origin_x_ff <= csr_data;
            tgi_pkg::CSR_ORIGIN_Y: origin_y_ff <= csr_data;
            tgi_pkg::CSR_ORIGIN_Z: origin_z_ff <= csr_data;
            tgi_pkg::CSR_SCALE_X:  scale_x_ff  <= csr_data;
            tgi_pkg::CSR_SCALE_Y:  scale_y_ff  <= csr_data;
            tgi_pkg::CSR_SCALE_Z:  scale_z_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   // stage valids and per-stage load enables
   logic [S-1:0] valid_ff, valid_in;
   logic [S-1:0] en;

   always_comb begin
      en[S-1] = !valid_ff[S-1] || !rsp_stall;
      for (int k = S - 2; k >= 0; k--) begin
         en[k] = !valid_ff[k] || en[k+1];
      end
   end

   assign req_stall = !en[0];

   // stage 0: input registers
   logic                              op0_ff;
   logic        [tgi_pkg::ADDR_W-1:0] taddr0_ff;
   logic        [tgi_pkg::DATA_W-1:0] tval0_ff;
   logic signed [tgi_pkg::DATA_W-1:0] cx0_ff, cy0_ff, cz0_ff;
   // write fields carried to the table stage
   logic                              op1_ff, op2_ff, op3_ff, op4_ff;
   logic        [tgi_pkg::ADDR_W-1:0] taddr1_ff, taddr2_ff, taddr3_ff, taddr4_ff;
   logic        [tgi_pkg::DATA_W-1:0] tval1_ff, tval2_ff, tval3_ff, tval4_ff;

   always_ff @(posedge clock) begin
      if (en[0]) begin
         op0_ff    <= req_operation;
         taddr0_ff <= req_table_address;
         tval0_ff  <= req_table_value;
         cx0_ff    <= req_coord_x;
         cy0_ff    <= req_coord_y;
         cz0_ff    <= req_coord_z;
      end
      if (en[1]) begin
         op1_ff    <= op0_ff;
         taddr1_ff <= taddr0_ff;
         tval1_ff  <= tval0_ff;
      end
      if (en[2]) begin
         op2_ff    <= op1_ff;
         taddr2_ff <= taddr1_ff;
         tval2_ff  <= tval1_ff;
      end
      if (en[3]) begin
         op3_ff    <= op2_ff;
         taddr3_ff <= taddr2_ff;
         tval3_ff  <= tval2_ff;
      end
      if (en[4]) begin
         op4_ff    <= op3_ff;
         taddr4_ff <= taddr3_ff;
         tval4_ff  <= tval3_ff;
      end
   end

   // stages 1..3: per-axis offset, scale and split
   tgi_pkg::axis_en_type              axis_en;
   logic        [tgi_pkg::IDX_W-1:0]  idx_a, idx_b, idx_c;
   logic signed [tgi_pkg::DATA_W-1:0] wt_a, wt_b, wt_c;
   logic                              clip_a, clip_b, clip_c;

   assign axis_en = '{diff: en[1], mul: en[2], split: en[3]};

   tgi_axis u_axis_x (
      .clock     (clock),
      .en        (axis_en),
      .coord     (cx0_ff),
      .origin    (origin_x_ff),
      .scale     (scale_x_ff),
      .max_index (tgi_pkg::IDX_W'(tgi_pkg::POINTS_X - 2)),
      .idx       (idx_a),
      .weight    (wt_a),
      .clipped   (clip_a)
   );

   tgi_axis u_axis_y (
      .clock     (clock),
      .en        (axis_en),
      .coord     (cy0_ff),
      .origin    (origin_y_ff),
      .scale     (scale_y_ff),
      .max_index (tgi_pkg::IDX_W'(tgi_pkg::POINTS_Y - 2)),
      .idx       (idx_b),
      .weight    (wt_b),
      .clipped   (clip_b)
   );

   tgi_axis u_axis_z (
      .clock     (clock),
      .en        (axis_en),
      .coord     (cz0_ff),
      .origin    (origin_z_ff),
      .scale     (scale_z_ff),
      .max_index (tgi_pkg::IDX_W'(tgi_pkg::POINTS_Z - 2)),
      .idx       (idx_c),
      .weight    (wt_c),
      .clipped   (clip_c)
   );

   // stage 4: corner addresses, wrapped to the table size
   logic [tgi_pkg::FLAT_W-1:0] base;
   logic [tgi_pkg::ADDR_W-1:0] caddr_in [tgi_pkg::CORNERS];
   logic [tgi_pkg::ADDR_W-1:0] caddr_ff [tgi_pkg::CORNERS];

   assign base = tgi_pkg::FLAT_W'(
                    tgi_pkg::FLAT_W'(tgi_pkg::FLAT_W'(idx_a) * tgi_pkg::FLAT_W'(tgi_pkg::POINTS_Y)
                                     + tgi_pkg::FLAT_W'(idx_b))
                    * tgi_pkg::FLAT_W'(tgi_pkg::POINTS_Z))
               + tgi_pkg::FLAT_W'(idx_c);

   always_comb begin
      logic [2:0]                 nb;
      logic [tgi_pkg::FLAT_W-1:0] flat;
      for (int n = 0; n < tgi_pkg::CORNERS; n++) begin
         nb   = 3'(n);
         flat = base
              + (nb[2] ? tgi_pkg::FLAT_W'(tgi_pkg::PLANE) : '0)
              + (nb[1] ? tgi_pkg::FLAT_W'(tgi_pkg::POINTS_Z) : '0)
              + tgi_pkg::FLAT_W'(nb[0]);
         caddr_in[n] = flat[tgi_pkg::ADDR_W-1:0];
      end
   end

   // weights and clip flag travel alongside
   logic signed [tgi_pkg::DATA_W-1:0] wa4_ff, wb4_ff, wc4_ff;
   logic signed [tgi_pkg::DATA_W-1:0] wa5_ff, wb5_ff, wc5_ff;
   logic signed [tgi_pkg::DATA_W-1:0] wa6_ff, wb6_ff, wa7_ff, wb7_ff;
   logic signed [tgi_pkg::DATA_W-1:0] wa8_ff, wa9_ff;
   logic flag4_ff, flag5_ff, flag6_ff, flag7_ff, flag8_ff, flag9_ff, flag10_ff, flag11_ff;

   logic [3:0] z_clip;
   logic [1:0] y_clip;
   logic       x_clip;

   always_ff @(posedge clock) begin
      if (en[4]) begin
         caddr_ff <= caddr_in;
         wa4_ff   <= wt_a;
         wb4_ff   <= wt_b;
         wc4_ff   <= wt_c;
         flag4_ff <= clip_a | clip_b | clip_c;
      end
      if (en[5]) begin
         wa5_ff   <= wa4_ff;
         wb5_ff   <= wb4_ff;
         wc5_ff   <= wc4_ff;
         flag5_ff <= flag4_ff;
      end
      if (en[6]) begin
         wa6_ff   <= wa5_ff;
         wb6_ff   <= wb5_ff;
         flag6_ff <= flag5_ff;
      end
      if (en[7]) begin
         wa7_ff   <= wa6_ff;
         wb7_ff   <= wb6_ff;
         flag7_ff <= flag6_ff;
      end
      if (en[8]) begin
         wa8_ff   <= wa7_ff;
         flag8_ff <= flag7_ff | (|z_clip);
      end
      if (en[9]) begin
         wa9_ff   <= wa8_ff;
         flag9_ff <= flag8_ff;
      end
      if (en[10]) begin
         flag10_ff <= flag9_ff | (|y_clip);
      end
      if (en[11]) begin
         flag11_ff <= flag10_ff;
      end
   end

   // table: a write lands as it leaves stage 4, where queries issue reads
   logic                              tbl_wr;
   logic        [tgi_pkg::DATA_W-1:0] corner_raw [tgi_pkg::CORNERS];
   logic signed [tgi_pkg::DATA_W-1:0] corner_val [tgi_pkg::CORNERS];

   assign tbl_wr = valid_ff[4] && (op4_ff == tgi_pkg::OP_WRITE) && en[5];

   for (genvar n = 0; n < tgi_pkg::CORNERS; n++) begin : g_bank
      tgi_ram #(
         .WIDTH (tgi_pkg::DATA_W),
         .DEPTH (tgi_pkg::TABLE_DEPTH)
      ) u_ram (
         .clock   (clock),
         .wr_en   (tbl_wr),
         .wr_addr (taddr4_ff),
         .wr_data (tval4_ff),
         .rd_en   (en[5]),
         .rd_addr (caddr_ff[n]),
         .rd_data (corner_raw[n])
      );
      assign corner_val[n] = $signed(corner_raw[n]);
   end

   // stages 6..11: blend along z, then y, then x
   logic signed [tgi_pkg::DATA_W-1:0] z_res [4];
   logic signed [tgi_pkg::DATA_W-1:0] y_res [2];
   logic signed [tgi_pkg::DATA_W-1:0] x_res;

   for (genvar i = 0; i < 4; i++) begin : g_lerp_z
      tgi_lerp u_lerp (
         .clock   (clock),
         .en      ('{mul: en[6], add: en[7]}),
         .a       (corner_val[2*i]),
         .b       (corner_val[2*i+1]),
         .w       (wc5_ff),
         .res     (z_res[i]),
         .clipped (z_clip[i])
      );
   end

   for (genvar i = 0; i < 2; i++) begin : g_lerp_y
      tgi_lerp u_lerp (
         .clock   (clock),
         .en      ('{mul: en[8], add: en[9]}),
         .a       (z_res[2*i]),
         .b       (z_res[2*i+1]),
         .w       (wb7_ff),
         .res     (y_res[i]),
         .clipped (y_clip[i])
      );
   end

   tgi_lerp u_lerp_x (
      .clock   (clock),
      .en      ('{mul: en[10], add: en[11]}),
      .a       (y_res[0]),
      .b       (y_res[1]),
      .w       (wa9_ff),
      .res     (x_res),
      .clipped (x_clip)
   );

   // valid bits; table writes drop out after stage 4
   always_comb begin
      for (int k = 0; k < S; k++) begin
         if (!en[k]) begin
            valid_in[k] = valid_ff[k];
         end else if (k == 0) begin
            valid_in[k] = req_valid;
         end else if (k == 5) begin
            valid_in[k] = valid_ff[4] && (op4_ff == tgi_pkg::OP_QUERY);
         end else begin
            valid_in[k] = valid_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign rsp_valid        = valid_ff[S-1];
   assign rsp_interpolated = x_res;
   assign rsp_saturated    = flag11_ff | x_clip;

endmodule

/* sv/tgi_checker.sv */
`timescale 1ns / 1ps
// Port-level checks of the trilinear grid interpolator, bound to the top level.
module tgi_protocol_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_stall,
   input logic                               req_operation,
   input logic        [tgi_pkg::ADDR_W-1:0]  req_table_address,
   input logic signed [tgi_pkg::DATA_W-1:0]  req_table_value,
   input logic signed [tgi_pkg::DATA_W-1:0]  req_coord_x,
   input logic signed [tgi_pkg::DATA_W-1:0]  req_coord_y,
   input logic signed [tgi_pkg::DATA_W-1:0]  req_coord_z,
   input logic                               rsp_valid,
   input logic                               rsp_stall,
   input logic signed [tgi_pkg::DATA_W-1:0]  rsp_interpolated,
   input logic                               rsp_saturated,
   input logic                               csr_valid,
   input logic                               csr_ready,
   input logic        [tgi_pkg::CSR_W-1:0]   csr_index,
   input logic        [tgi_pkg::DATA_W-1:0]  csr_data
);

   // input backs up only when a result is stuck at the output
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("input stalled without a stalled result");

   // nothing comes out right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid)
      else $error("stalled result dropped");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> ($stable(rsp_interpolated) && $stable(rsp_saturated)))
      else $error("stalled result changed");

endmodule

bind trilinear_grid_interpolation tgi_protocol_checker u_tgi_protocol_checker (.*);
